// ===== hdl/tabe_pkg.sv =====
// ----------------------------------------------------------------------------
// tabe_pkg
// Shared types and constants of the Thumb ALU and branch execute core.
// ----------------------------------------------------------------------------
package tabe_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned REG_AW    = 4;
   localparam int unsigned REG_DEPTH = 16;

   localparam logic [REG_AW-1:0] PC_IDX = 4'd15;
   localparam logic [REG_AW-1:0] LR_IDX = 4'd14;

   localparam logic [XLEN-1:0] HALT_PC = 32'hFFFF_FFFF;

   // Bit positions inside the N Z C V status nibble
   localparam int unsigned FLAG_N = 3;
   localparam int unsigned FLAG_Z = 2;
   localparam int unsigned FLAG_C = 1;
   localparam int unsigned FLAG_V = 0;

   // Handler selector; codes above UNIMPL behave as UNIMPL
   typedef enum logic [4:0] {
      FUNC_ADDIMM3 = 5'd0,
      FUNC_SUBIMM3 = 5'd1,
      FUNC_MOVIMM8 = 5'd2,
      FUNC_ADDREG  = 5'd3,
      FUNC_SUBREG  = 5'd4,
      FUNC_CMP     = 5'd5,
      FUNC_AND     = 5'd6,
      FUNC_EOR     = 5'd7,
      FUNC_ORR     = 5'd8,
      FUNC_BIC     = 5'd9,
      FUNC_MVN     = 5'd10,
      FUNC_LSL     = 5'd11,
      FUNC_LSR     = 5'd12,
      FUNC_ASR     = 5'd13,
      FUNC_BCOND   = 5'd14,
      FUNC_BL      = 5'd15,
      FUNC_BX      = 5'd16,
      FUNC_BKPT    = 5'd17,
      FUNC_NOP     = 5'd18,
      FUNC_UDF     = 5'd19,
      FUNC_UNIMPL  = 5'd20
   } func_type;

   // Branch conditions; codes eight and up are never taken
   typedef enum logic [3:0] {
      COND_ZC_SET   = 4'd0,
      COND_ZC_CLEAR = 4'd1,
      COND_C_SET    = 4'd2,
      COND_C_CLEAR  = 4'd3,
      COND_N_SET    = 4'd4,
      COND_N_CLEAR  = 4'd5,
      COND_V_SET    = 4'd6,
      COND_V_CLEAR  = 4'd7
   } cond_type;

   // Register file write port
   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] idx;
      logic [XLEN-1:0]   data;
   } wr_port_type;

   // Outcome of one executed request
   typedef struct packed {
      logic              wr_en;
      logic [REG_AW-1:0] wr_idx;
      logic [XLEN-1:0]   wr_data;
      logic [XLEN-1:0]   pc;
      logic              taken;
      logic [3:0]        flags;
      logic              halt;
   } exec_res_type;

endpackage

// ===== hdl/tabe_regfile.sv =====
// ----------------------------------------------------------------------------
// tabe_regfile
// Register file memory with two registered read ports, per-entry valid bits
// cleared by reset, and a bypass from the write that lands on the read edge.
// ----------------------------------------------------------------------------
module tabe_regfile (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rd_en,
   input  logic [tabe_pkg::REG_AW-1:0]           rd_addr_a,
   input  logic [tabe_pkg::REG_AW-1:0]           rd_addr_b,
   input  tabe_pkg::wr_port_type                 wr,
   input  logic [tabe_pkg::XLEN-1:0]             pc,
   output logic [tabe_pkg::XLEN-1:0]             opnd_a,
   output logic [tabe_pkg::XLEN-1:0]             opnd_b
);

   logic [tabe_pkg::XLEN-1:0]      mem [tabe_pkg::REG_DEPTH];
   logic [tabe_pkg::REG_DEPTH-1:0] valid_ff;

   logic [tabe_pkg::XLEN-1:0]   rdata_a_ff, rdata_b_ff;
   logic                        rvld_a_ff, rvld_b_ff;
   logic [tabe_pkg::REG_AW-1:0] raddr_a_ff, raddr_b_ff;
   tabe_pkg::wr_port_type       wb_ff;

   logic mem_we;
   assign mem_we = wr.en && (wr.idx != tabe_pkg::PC_IDX);

   // Write the memory; the program counter lives outside it
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr.idx] <= wr.data;
      end
   end

   // Mark written entries; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   // Read both ports when a request is taken
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_a_ff <= mem[rd_addr_a];
         rdata_b_ff <= mem[rd_addr_b];
         rvld_a_ff  <= valid_ff[rd_addr_a];
         rvld_b_ff  <= valid_ff[rd_addr_b];
         raddr_a_ff <= rd_addr_a;
         raddr_b_ff <= rd_addr_b;
      end
   end

   // Capture the write that lands on the read edge; hold it with the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff.en <= 1'b0;
      end else if (rd_en) begin
         wb_ff.en <= mem_we;
      end
      if (rd_en) begin
         wb_ff.idx  <= wr.idx;
         wb_ff.data <= wr.data;
      end
   end

   // Select PC, bypassed write or memory data
   always_comb begin
      if (raddr_a_ff == tabe_pkg::PC_IDX) begin
         opnd_a = pc;
      end else if (wb_ff.en && (wb_ff.idx == raddr_a_ff)) begin
         opnd_a = wb_ff.data;
      end else if (rvld_a_ff) begin
         opnd_a = rdata_a_ff;
      end else begin
         opnd_a = '0;
      end

      if (raddr_b_ff == tabe_pkg::PC_IDX) begin
         opnd_b = pc;
      end else if (wb_ff.en && (wb_ff.idx == raddr_b_ff)) begin
         opnd_b = wb_ff.data;
      end else if (rvld_b_ff) begin
         opnd_b = rdata_b_ff;
      end else begin
         opnd_b = '0;
      end
   end

   // A bypassed entry must already be marked written
   a_bypass_valid: assert property (@(posedge clock) disable iff (reset)
      wb_ff.en |-> valid_ff[wb_ff.idx])
      else $error("bypass entry not marked valid");

   // The program counter never goes into the memory
   a_no_pc_write: assert property (@(posedge clock) disable iff (reset)
      wb_ff.en |-> (wb_ff.idx != tabe_pkg::PC_IDX))
      else $error("memory write to PC index");

   // A write sets the valid bit of its entry
   a_valid_set: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> valid_ff[$past(wr.idx)])
      else $error("valid bit not set after write");

endmodule

// ===== hdl/tabe_alu.sv =====
// ----------------------------------------------------------------------------
// tabe_alu
// Execute logic: arithmetic, logic, shifts, compare, branches and halts for
// one request, from the operands, the program counter and the flags.
// ----------------------------------------------------------------------------
module tabe_alu (
   input  logic [4:0]                 func,
   input  logic [15:0]                ins,
   input  logic [15:0]                ins2,
   input  logic [tabe_pkg::XLEN-1:0]  opnd_a,
   input  logic [tabe_pkg::XLEN-1:0]  opnd_b,
   input  logic [tabe_pkg::XLEN-1:0]  pc,
   input  logic [3:0]                 flags,
   output tabe_pkg::exec_res_type     res
);

   logic [2:0]                rd;
   logic [2:0]                imm3;
   logic [4:0]                imm5;
   logic [4:0]                asr_amt;
   logic [tabe_pkg::XLEN-1:0] diff;
   logic [tabe_pkg::XLEN-1:0] asr_val;
   logic [tabe_pkg::XLEN-1:0] b_off;
   logic [tabe_pkg::XLEN-1:0] bl_off;
   logic [tabe_pkg::XLEN-1:0] bl_next;
   logic [tabe_pkg::XLEN-1:0] bl_target;
   logic                      cond_ok;
   logic                      cmp_zero;

   assign rd        = ins[2:0];
   assign imm3      = ins[8:6];
   assign imm5      = ins[10:6];
   assign asr_amt   = (imm5 == 5'd0) ? 5'd1 : imm5;
   assign diff      = opnd_a - opnd_b;
   assign asr_val   = 32'($signed(opnd_b) >>> asr_amt);
   assign b_off     = {{23{ins[7]}}, ins[7:0], 1'b0};
   assign bl_off    = {{9{ins[10]}}, ins[10:0], ins2[10:0], 1'b0};
   assign bl_next   = pc + 32'd4;
   assign bl_target = bl_next + bl_off;
   assign cmp_zero  = (diff == '0);

   // Evaluate the branch condition
   always_comb begin
      unique case (tabe_pkg::cond_type'(ins[11:8]))
         tabe_pkg::COND_ZC_SET:
            cond_ok = flags[tabe_pkg::FLAG_Z] | flags[tabe_pkg::FLAG_C];
         tabe_pkg::COND_ZC_CLEAR:
            cond_ok = !(flags[tabe_pkg::FLAG_Z] | flags[tabe_pkg::FLAG_C]);
         tabe_pkg::COND_C_SET:   cond_ok = flags[tabe_pkg::FLAG_C];
         tabe_pkg::COND_C_CLEAR: cond_ok = !flags[tabe_pkg::FLAG_C];
         tabe_pkg::COND_N_SET:   cond_ok = flags[tabe_pkg::FLAG_N];
         tabe_pkg::COND_N_CLEAR: cond_ok = !flags[tabe_pkg::FLAG_N];
         tabe_pkg::COND_V_SET:   cond_ok = flags[tabe_pkg::FLAG_V];
         tabe_pkg::COND_V_CLEAR: cond_ok = !flags[tabe_pkg::FLAG_V];
         default:                cond_ok = 1'b0;
      endcase
   end

   // Decode the handler and form the outcome
   always_comb begin
      res         = '0;
      res.pc      = pc;
      res.flags   = flags;
      res.wr_idx  = {1'b0, rd};
      unique case (tabe_pkg::func_type'(func))
         tabe_pkg::FUNC_ADDIMM3: begin
            res.wr_en   = 1'b1;
            res.wr_data = opnd_b + 32'(imm3);
         end
         tabe_pkg::FUNC_SUBIMM3: begin
            res.wr_en   = 1'b1;
            res.wr_data = opnd_b - 32'(imm3);
         end
         tabe_pkg::FUNC_MOVIMM8: begin
            res.wr_en   = 1'b1;
            res.wr_idx  = {1'b0, ins[10:8]};
            res.wr_data = 32'(ins[7:0]);
         end
         tabe_pkg::FUNC_ADDREG: begin
            res.wr_en   = 1'b1;
            res.wr_idx  = {ins[7], rd};
            res.wr_data = opnd_a + opnd_b;
            if ({ins[7], rd} == tabe_pkg::PC_IDX) begin
               res.pc = opnd_a + opnd_b;
            end
         end
         tabe_pkg::FUNC_SUBREG: begin
            res.wr_en   = 1'b1;
            res.wr_data = diff;
         end
         tabe_pkg::FUNC_CMP: begin
            res.wr_idx = '0;
            res.flags  = {diff[31], cmp_zero, cmp_zero, 1'b0};
         end
         tabe_pkg::FUNC_AND: begin
            res.wr_en   = 1'b1;
            res.wr_data = opnd_a & opnd_b;
         end
         tabe_pkg::FUNC_EOR: begin
            res.wr_en   = 1'b1;
            res.wr_data = opnd_a ^ opnd_b;
         end
         tabe_pkg::FUNC_ORR: begin
            res.wr_en   = 1'b1;
            res.wr_data = opnd_a | opnd_b;
         end
         tabe_pkg::FUNC_BIC: begin
            res.wr_en   = 1'b1;
            res.wr_data = opnd_a & ~opnd_b;
         end
         tabe_pkg::FUNC_MVN: begin
            res.wr_en   = 1'b1;
            res.wr_data = ~opnd_b;
         end
         tabe_pkg::FUNC_LSL: begin
            res.wr_en   = 1'b1;
            res.wr_data = opnd_b << imm5;
         end
         tabe_pkg::FUNC_LSR: begin
            res.wr_en   = 1'b1;
            res.wr_data = (imm5 == 5'd0) ? '0 : (opnd_b >> imm5);
         end
         tabe_pkg::FUNC_ASR: begin
            res.wr_en   = 1'b1;
            res.wr_data = asr_val;
         end
         tabe_pkg::FUNC_BCOND: begin
            res.wr_idx = '0;
            if (cond_ok) begin
               res.pc    = pc + b_off;
               res.taken = 1'b1;
            end
         end
         tabe_pkg::FUNC_BL: begin
            res.wr_en   = 1'b1;
            res.wr_idx  = tabe_pkg::LR_IDX;
            res.wr_data = {bl_next[31:1], 1'b1};
            res.pc      = {bl_target[31:1], 1'b0};
            res.taken   = 1'b1;
         end
         tabe_pkg::FUNC_BX: begin
            res.wr_idx = '0;
            res.pc     = {opnd_b[31:1], 1'b0};
            res.taken  = 1'b1;
         end
         tabe_pkg::FUNC_NOP: begin
            res.wr_idx = '0;
         end
         default: begin
            // breakpoint, undefined, unimplemented and unused selectors
            res.wr_idx = '0;
            res.pc     = tabe_pkg::HALT_PC;
            res.halt   = 1'b1;
         end
      endcase
   end

endmodule

// ===== hdl/thumb_alu_branch_execute_core.sv =====
// ----------------------------------------------------------------------------
// thumb_alu_branch_execute_core
// Executes one Thumb halfword, or a BL halfword pair, per request against a
// sixteen-entry register file held in a synchronous memory, with the PC and
// flags in registers.
// Pipeline: an accepted request passes the execute stage, then the response
// register. Throughput: one request per cycle unless a stalled response
// holds the execute stage; the memory is read on the acceptance edge and
// written when the request retires, with a bypass from that write.
// Reset clears valid bits, PC and flags at once; no clearing pass is needed.
// Unwritten register entries read as zero.
// ----------------------------------------------------------------------------
module thumb_alu_branch_execute_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_func,
   input  logic [15:0] req_instruction,
   input  logic [15:0] req_second_half,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_dest_written,
   output logic [3:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic [31:0] rsp_pc_value,
   output logic        rsp_branch_taken,
   output logic [3:0]  rsp_flags_value,
   output logic        rsp_halted
);

   logic        s1_vld_ff;
   logic [4:0]  s1_func_ff;
   logic [15:0] s1_ins_ff;
   logic [15:0] s1_ins2_ff;

   logic [tabe_pkg::XLEN-1:0] pc_ff;
   logic [3:0]                flags_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_written_ff;
   logic [3:0]  rsp_index_ff;
   logic [31:0] rsp_value_ff;
   logic [31:0] rsp_pc_ff;
   logic        rsp_taken_ff;
   logic [3:0]  rsp_flags_ff;
   logic        rsp_halted_ff;

   logic                        s1_adv;
   logic                        req_acc;
   logic [tabe_pkg::REG_AW-1:0] rd_addr_a, rd_addr_b;
   logic [tabe_pkg::XLEN-1:0]   opnd_a, opnd_b;
   tabe_pkg::exec_res_type      res;
   tabe_pkg::wr_port_type       wr;
   logic                        use_rm4;

   // Advance the execute stage when the response register can take it
   assign s1_adv    = s1_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   // Pick read addresses from the incoming request
   assign use_rm4 = (req_func == tabe_pkg::FUNC_ADDREG) ||
                    (req_func == tabe_pkg::FUNC_CMP)    ||
                    (req_func == tabe_pkg::FUNC_BX);
   assign rd_addr_a = (req_func == tabe_pkg::FUNC_ADDREG) ?
                      {req_instruction[7], req_instruction[2:0]} :
                      {1'b0, req_instruction[2:0]};
   assign rd_addr_b = use_rm4 ? req_instruction[6:3] : {1'b0, req_instruction[5:3]};

   // Retire into the register file
   assign wr.en   = s1_adv && res.wr_en;
   assign wr.idx  = res.wr_idx;
   assign wr.data = res.wr_data;

   tabe_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_acc),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr        (wr),
      .pc        (pc_ff),
      .opnd_a    (opnd_a),
      .opnd_b    (opnd_b)
   );

   tabe_alu u_alu (
      .func   (s1_func_ff),
      .ins    (s1_ins_ff),
      .ins2   (s1_ins2_ff),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .pc     (pc_ff),
      .flags  (flags_ff),
      .res    (res)
   );

   // Hold the request in the execute stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_acc) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_func_ff <= req_func;
         s1_ins_ff  <= req_instruction;
         s1_ins2_ff <= req_second_half;
      end
   end

   // Update PC and flags as each request retires
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         flags_ff <= '0;
      end else if (s1_adv) begin
         pc_ff    <= res.pc;
         flags_ff <= res.flags;
      end
   end

   // Response register
   always_comb begin
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_written_ff <= res.wr_en;
         rsp_index_ff   <= res.wr_en ? res.wr_idx : '0;
         rsp_value_ff   <= res.wr_en ? res.wr_data : '0;
         rsp_pc_ff      <= res.pc;
         rsp_taken_ff   <= res.taken;
         rsp_flags_ff   <= res.flags;
         rsp_halted_ff  <= res.halt;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dest_written = rsp_written_ff;
   assign rsp_dest_index   = rsp_index_ff;
   assign rsp_dest_value   = rsp_value_ff;
   assign rsp_pc_value     = rsp_pc_ff;
   assign rsp_branch_taken = rsp_taken_ff;
   assign rsp_flags_value  = rsp_flags_ff;
   assign rsp_halted       = rsp_halted_ff;

   // A halting response always parks the PC at all ones
   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_halted) |-> (rsp_pc_value == tabe_pkg::HALT_PC))
      else $error("halt without halt PC");

   // Halt and taken branch never come together
   a_halt_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_halted && rsp_branch_taken))
      else $error("halt reported with taken branch");

   // A response without a write reports index and value zero
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_dest_written) |-> (rsp_dest_index == '0 && rsp_dest_value == '0))
      else $error("nonzero destination without write");

   // Reported PC matches the retired PC register
   a_pc_track: assert property (@(posedge clock) disable iff (reset)
      $past(s1_adv) && !$past(reset) |-> (rsp_pc_value == pc_ff))
      else $error("response PC differs from PC register");

endmodule
